### rtl/core/urxf_pkg.sv
// ----------------------------------------------------------------------------
// urxf_pkg
// Shared types and constants for the UART register block with receive ring.
// ----------------------------------------------------------------------------
package urxf_pkg;

    localparam int          FIFO_DEPTH_DEF  = 16;
    localparam logic [31:0] TX_ADDR_DEF     = 32'h1000_0000;
    localparam logic [31:0] RX_ADDR_DEF     = 32'h1000_0004;
    localparam logic [31:0] STATUS_ADDR_DEF = 32'h1000_0008;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [7:0] RD_EMPTY     = 8'hFF;
    localparam logic [7:0] STS_TX_READY = 8'h02;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_done;
    } t_cmd;

    typedef struct packed {
        logic pop;
    } t_sts;

endpackage

### rtl/core/urxf_ctrl.sv
// ----------------------------------------------------------------------------
// urxf_ctrl
// Request sequencer: capture, execute, and the extra pop state of an RX read.
// ----------------------------------------------------------------------------
module urxf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  urxf_pkg::t_sts i_sts,
    output urxf_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.capture   = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.pop_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.pop ? S_POP : S_IDLE;
            end
            S_POP: begin
                o_cmd.pop_done = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_pop_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(r_state == S_EXEC))
        else $error("pop cycle without execute");

    a_exec_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("capture not followed by execute");

endmodule

### rtl/core/urxf_dp.sv
// ----------------------------------------------------------------------------
// urxf_dp
// Datapath: captured request, receive ring memory, pointers, interrupt flag
// and result registers.
// ----------------------------------------------------------------------------
module urxf_dp #(
    parameter int          FIFO_DEPTH  = urxf_pkg::FIFO_DEPTH_DEF,
    parameter logic [31:0] TX_ADDR     = urxf_pkg::TX_ADDR_DEF,
    parameter logic [31:0] RX_ADDR     = urxf_pkg::RX_ADDR_DEF,
    parameter logic [31:0] STATUS_ADDR = urxf_pkg::STATUS_ADDR_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  urxf_pkg::t_cmd i_cmd,
    output urxf_pkg::t_sts o_sts,
    input  logic [1:0]     i_opcode,
    input  logic [31:0]    i_address,
    input  logic [31:0]    i_write_data,
    input  logic [7:0]     i_rx_byte,
    output logic           o_valid,
    output logic [7:0]     o_read_data,
    output logic           o_tx_valid,
    output logic [7:0]     o_tx_byte,
    output logic           o_irq_valid
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [1:0]       r_opcode;
    logic [31:0]      r_address;
    logic [7:0]       r_wdata;
    logic [7:0]       r_rx_byte;

    logic [7:0]       r_mem [FIFO_DEPTH];
    logic [7:0]       r_mem_q;

    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr;
    logic             r_irq_armed;

    logic             r_valid;
    logic [7:0]       r_read_data;
    logic             r_tx_valid;
    logic [7:0]       r_tx_byte;
    logic             r_irq_valid;

    logic [PTR_W-1:0] w_rd_next;
    logic [PTR_W-1:0] w_wr_next;
    logic             w_empty;
    logic             w_full;
    logic             w_push;
    logic [7:0]       n_read_data;
    logic             n_tx_valid;
    logic [7:0]       n_tx_byte;
    logic             n_irq_valid;

    assign w_rd_next = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
    assign w_wr_next = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign w_empty   = (r_rd_ptr == r_wr_ptr);
    assign w_full    = (w_wr_next == r_rd_ptr);
    assign w_push    = i_cmd.exec && (r_opcode == urxf_pkg::OP_RX) && !w_full;
    assign o_sts.pop = (r_opcode == urxf_pkg::OP_READ) && (r_address == RX_ADDR) && !w_empty;

    always_comb begin
        n_read_data = '0;
        n_tx_valid  = 1'b0;
        n_tx_byte   = '0;
        n_irq_valid = 1'b0;
        unique case (r_opcode)
            urxf_pkg::OP_READ: begin
                if (r_address == RX_ADDR) begin
                    n_read_data = urxf_pkg::RD_EMPTY;
                end else if (r_address == STATUS_ADDR) begin
                    n_read_data = urxf_pkg::STS_TX_READY | {7'd0, !w_empty};
                end
            end
            urxf_pkg::OP_WRITE: begin
                if (r_address == TX_ADDR) begin
                    n_tx_valid = 1'b1;
                    n_tx_byte  = r_wdata;
                end
            end
            urxf_pkg::OP_RX: begin
                n_read_data = '0;
            end
            urxf_pkg::OP_TICK: begin
                n_irq_valid = r_irq_armed;
            end
            default: begin
                n_read_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode  <= i_opcode;
            r_address <= i_address;
            r_wdata   <= i_write_data[7:0];
            r_rx_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= r_rx_byte;
        end
        r_mem_q <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_irq_armed <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= (i_cmd.exec && !o_sts.pop) || i_cmd.pop_done;
            if (i_cmd.exec && o_sts.pop) begin
                r_rd_ptr <= w_rd_next;
            end
            if (w_push) begin
                r_wr_ptr    <= w_wr_next;
                r_irq_armed <= 1'b1;
            end else if (i_cmd.exec && (r_opcode == urxf_pkg::OP_TICK)) begin
                r_irq_armed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_data <= n_read_data;
            r_tx_valid  <= n_tx_valid;
            r_tx_byte   <= n_tx_byte;
            r_irq_valid <= n_irq_valid;
        end else if (i_cmd.pop_done) begin
            r_read_data <= r_mem_q;
            r_tx_valid  <= 1'b0;
            r_tx_byte   <= '0;
            r_irq_valid <= 1'b0;
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_read_data;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_irq_valid = r_irq_valid;

    a_valid_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_cmd.exec || i_cmd.pop_done))
        else $error("result strobe without a request");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rd_ptr} < (PTR_W+1)'(FIFO_DEPTH)) &&
        ({1'b0, r_wr_ptr} < (PTR_W+1)'(FIFO_DEPTH)))
        else $error("ring pointer out of range");

    a_irq_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_armed) |-> $past(w_push))
        else $error("interrupt armed without a stored byte");

    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_empty)
        else $error("ring empty after a stored byte");

endmodule

### rtl/core/uart_rx_fifo_registers.sv
// ----------------------------------------------------------------------------
// uart_rx_fifo_registers
// Register view of a simple UART: bus reads and writes, received bytes into
// a receive ring, and interrupt report on tick.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with o_valid; the receiver cannot
// stall it, so sample it on that cycle. A request holds busy through the
// execute state; a read of the RX address with data in the ring also holds
// it through a pop state, for the registered read port of the ring memory.
// The result strobe comes in the first cycle with busy low again, and the
// next request may start in that same cycle. The ring keeps at most
// FIFO_DEPTH-1 bytes; further bytes are dropped.
// ----------------------------------------------------------------------------
module uart_rx_fifo_registers #(
    parameter int          FIFO_DEPTH  = urxf_pkg::FIFO_DEPTH_DEF,
    parameter logic [31:0] TX_ADDR     = urxf_pkg::TX_ADDR_DEF,
    parameter logic [31:0] RX_ADDR     = urxf_pkg::RX_ADDR_DEF,
    parameter logic [31:0] STATUS_ADDR = urxf_pkg::STATUS_ADDR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    output logic [7:0]  o_read_data,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_irq_valid
);

    urxf_pkg::t_cmd w_cmd;
    urxf_pkg::t_sts w_sts;

    urxf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    urxf_dp #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .TX_ADDR     (TX_ADDR),
        .RX_ADDR     (RX_ADDR),
        .STATUS_ADDR (STATUS_ADDR)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_irq_valid  (o_irq_valid)
    );

endmodule
